@@ hw/rtl/tksk_pkg.sv @@
// ----------------------------------------------------------------------------
// tksk_pkg: shared types and constants of the top-k score keeper
// Holds the op codes, the queue entry type and the default sizes.
// ----------------------------------------------------------------------------
`default_nettype none

package tksk_pkg;

    localparam int unsigned CAPACITY_DEF = 64;
    localparam int unsigned CMD_DEPTH    = 2;
    localparam logic [6:0]  KEEP_RESET   = 7'd64;

    // op codes of an input beat
    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_READ   = 2'd1,
        OP_CLEAR  = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    // command handed from the front to the back
    typedef struct packed {
        op_t         op;
        logic [15:0] score;
        logic [14:0] pack_no;
        logic [31:0] struct_offset;
        logic [15:0] start_pos;
    } cmd_t;

    // back-end sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_WRITE,
        ST_SEL,
        ST_EMIT,
        ST_EMPTY
    } state_t;

endpackage

`default_nettype wire

@@ hw/rtl/tksk_front.sv @@
// ----------------------------------------------------------------------------
// tksk_front: input stage and command queue
// Accepts input beats, drops op 3, and queues commands for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module tksk_front (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire tksk_pkg::cmd_t  in_cmd,
    output logic                 cmd_valid,
    input  wire logic            cmd_ready,
    output tksk_pkg::cmd_t       cmd
);

    localparam int unsigned DEPTH = tksk_pkg::CMD_DEPTH;
    localparam int unsigned AW    = $clog2(DEPTH);

    tksk_pkg::cmd_t     q_mem [DEPTH];
    logic [AW-1:0]      wr_ptr_reg, rd_ptr_reg;
    logic [AW:0]        fill_reg;
    logic               push, pop;

    // queue control
    assign in_ready  = (fill_reg != (AW+1)'(DEPTH));
    assign cmd_valid = (fill_reg != '0);
    assign pop       = cmd_valid && cmd_ready;
    assign push      = in_valid && in_ready && (in_cmd.op != tksk_pkg::OP_NONE);
    assign cmd       = q_mem[rd_ptr_reg];

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg] <= in_cmd;
        end
    end

    // pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH-1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH-1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            fill_reg <= fill_reg + (AW+1)'(push) - (AW+1)'(pop);
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/tksk_back.sv @@
// ----------------------------------------------------------------------------
// tksk_back: record store and scan sequencer
// A full-store insert and a read-out scan the store one slot per cycle; clear zeroes count.
// ----------------------------------------------------------------------------
`default_nettype none

module tksk_back #(
    parameter int unsigned CAPACITY = tksk_pkg::CAPACITY_DEF
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic [6:0]      max_keep,
    input  wire logic            cmd_valid,
    output logic                 cmd_ready,
    input  wire tksk_pkg::cmd_t  cmd,
    output logic                 out_valid,
    input  wire logic            out_ready,
    output logic                 valid_res,
    output logic [15:0]          out_score,
    output logic [14:0]          out_pack,
    output logic [31:0]          out_offset,
    output logic [15:0]          out_start,
    output logic                 last
);

    localparam int unsigned SW = $clog2(CAPACITY);
    localparam int unsigned CW = $clog2(CAPACITY + 1);

    // record store
    logic [15:0] sc_mem [CAPACITY];
    logic [14:0] pk_mem [CAPACITY];
    logic [31:0] of_mem [CAPACITY];
    logic [15:0] st_mem [CAPACITY];

    tksk_pkg::state_t state_reg, state_next;
    tksk_pkg::cmd_t   cur_reg,   cur_next;
    logic [CW-1:0]    count_reg, count_next;
    logic [CW-1:0]    idx_reg,   idx_next;
    logic [CW-1:0]    done_reg,  done_next;
    logic [CW-1:0]    nout_reg,  nout_next;
    logic [SW-1:0]    best_reg,  best_next;
    logic             have_reg,  have_next;
    logic [CAPACITY-1:0] mask_reg, mask_next;
    logic [15:0]      bsc_reg,   bsc_next;
    logic [14:0]      bpk_reg,   bpk_next;
    logic [31:0]      bof_reg,   bof_next;
    logic             ov_reg,    ov_next;
    logic             ovr_reg,   ovr_next;
    logic             olast_reg, olast_next;
    logic [SW-1:0]    rd_slot;
    logic [15:0]      rd_sc;
    logic [14:0]      rd_pk;
    logic [31:0]      rd_of;
    logic             wr_en;
    logic [SW-1:0]    wr_slot;
    logic [CW-1:0]    keep;
    logic             better;
    logic             out_free;

    // effective limit, saturated to 1..CAPACITY
    always_comb
    begin
        if (max_keep == 7'd0)
            keep = CW'(1);
        else if (32'(max_keep) > CAPACITY)
            keep = CW'(CAPACITY);
        else
            keep = CW'(max_keep);
    end

    // registered store read; the address is the next scan index, so the
    // data lines up with idx_reg in the cycle that uses it
    assign rd_slot = idx_reg[SW-1:0];

    always_ff @(posedge clk)
    begin
        rd_sc <= sc_mem[idx_next[SW-1:0]];
        rd_pk <= pk_mem[idx_next[SW-1:0]];
        rd_of <= of_mem[idx_next[SW-1:0]];
    end

    // ordering compare against the current best
    always_comb
    begin
        if (rd_sc != bsc_reg)
            better = rd_sc > bsc_reg;
        else if (rd_pk != bpk_reg)
            better = rd_pk < bpk_reg;
        else
            better = rd_of < bof_reg;
    end

    // store write
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            sc_mem[wr_slot] <= cur_reg.score;
            pk_mem[wr_slot] <= cur_reg.pack_no;
            of_mem[wr_slot] <= cur_reg.struct_offset;
            st_mem[wr_slot] <= cur_reg.start_pos;
        end
    end

    assign out_free = !ov_reg || out_ready;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tksk_pkg::ST_IDLE;
            count_reg <= '0;
            mask_reg  <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            mask_reg  <= mask_next;
            ov_reg    <= ov_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        cur_reg   <= cur_next;
        idx_reg   <= idx_next;
        done_reg  <= done_next;
        nout_reg  <= nout_next;
        best_reg  <= best_next;
        have_reg  <= have_next;
        bsc_reg   <= bsc_next;
        bpk_reg   <= bpk_next;
        bof_reg   <= bof_next;
        ovr_reg   <= ovr_next;
        olast_reg <= olast_next;
    end

    // output register fields
    logic [15:0] osc_reg;
    logic [14:0] opk_reg;
    logic [31:0] oof_reg;
    logic        load_out;
    assign load_out = (state_reg == tksk_pkg::ST_EMIT) && out_free;

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            osc_reg <= bsc_reg;
            opk_reg <= bpk_reg;
            oof_reg <= bof_reg;
        end
        else if ((state_reg == tksk_pkg::ST_EMPTY) && out_free)
        begin
            osc_reg <= '0;
            opk_reg <= '0;
            oof_reg <= '0;
        end
    end

    // start field read straight into the output register for the chosen slot
    logic [15:0] ost_reg;
    always_ff @(posedge clk)
    begin
        if (load_out)
            ost_reg <= st_mem[best_reg];
        else if ((state_reg == tksk_pkg::ST_EMPTY) && out_free)
            ost_reg <= '0;
    end

    assign out_valid  = ov_reg;
    assign valid_res  = ovr_reg;
    assign out_score  = osc_reg;
    assign out_pack   = opk_reg;
    assign out_offset = oof_reg;
    assign out_start  = ost_reg;
    assign last       = olast_reg;

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        cur_next   = cur_reg;
        count_next = count_reg;
        idx_next   = idx_reg;
        done_next  = done_reg;
        nout_next  = nout_reg;
        best_next  = best_reg;
        have_next  = have_reg;
        mask_next  = mask_reg;
        bsc_next   = bsc_reg;
        bpk_next   = bpk_reg;
        bof_next   = bof_reg;
        ov_next    = ov_reg && !out_ready;
        ovr_next   = ovr_reg;
        olast_next = olast_reg;
        cmd_ready  = 1'b0;
        wr_en      = 1'b0;
        wr_slot    = best_reg;

        unique case (state_reg)
            tksk_pkg::ST_IDLE:
            begin
                cmd_ready = 1'b1;
                if (cmd_valid)
                begin
                    cur_next = cmd;
                    idx_next = '0;
                    unique case (cmd.op)
                        tksk_pkg::OP_INSERT:
                        begin
                            if (count_reg < keep)
                            begin
                                best_next  = count_reg[SW-1:0];
                                state_next = tksk_pkg::ST_WRITE;
                            end
                            else
                            begin
                                best_next  = '0;
                                bsc_next   = 16'hFFFF;
                                have_next  = 1'b0;
                                state_next = tksk_pkg::ST_SCAN;
                            end
                        end
                        tksk_pkg::OP_READ:
                        begin
                            if (count_reg == '0)
                                state_next = tksk_pkg::ST_EMPTY;
                            else
                            begin
                                nout_next  = (count_reg < keep) ? count_reg : keep;
                                done_next  = '0;
                                mask_next  = '0;
                                have_next  = 1'b0;
                                state_next = tksk_pkg::ST_SEL;
                            end
                        end
                        tksk_pkg::OP_CLEAR:
                        begin
                            count_next = '0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            // minimum search over occupied slots, lowest slot on ties
            tksk_pkg::ST_SCAN:
            begin
                if (!have_reg || rd_sc < bsc_reg)
                begin
                    best_next = rd_slot;
                    bsc_next  = rd_sc;
                    have_next = 1'b1;
                end
                idx_next = idx_reg + 1'b1;
                if (idx_reg + 1'b1 == count_reg)
                    state_next = tksk_pkg::ST_WRITE;
            end
            tksk_pkg::ST_WRITE:
            begin
                if (count_reg < keep)
                begin
                    wr_en      = 1'b1;
                    count_next = count_reg + 1'b1;
                end
                else if (cur_reg.score > bsc_reg)
                begin
                    wr_en = 1'b1;
                end
                state_next = tksk_pkg::ST_IDLE;
            end
            // selection pass for the next record in output order
            tksk_pkg::ST_SEL:
            begin
                if (!mask_reg[rd_slot] && (!have_reg || better))
                begin
                    best_next = rd_slot;
                    bsc_next  = rd_sc;
                    bpk_next  = rd_pk;
                    bof_next  = rd_of;
                    have_next = 1'b1;
                end
                idx_next = idx_reg + 1'b1;
                if (idx_reg + 1'b1 == count_reg)
                    state_next = tksk_pkg::ST_EMIT;
            end
            tksk_pkg::ST_EMIT:
            begin
                if (out_free)
                begin
                    ov_next    = 1'b1;
                    ovr_next   = 1'b1;
                    olast_next = (done_reg + 1'b1 == nout_reg);
                    mask_next  = mask_reg | (CAPACITY'(1) << best_reg);
                    done_next  = done_reg + 1'b1;
                    idx_next   = '0;
                    have_next  = 1'b0;
                    if (done_reg + 1'b1 == nout_reg)
                    begin
                        mask_next  = '0;
                        state_next = tksk_pkg::ST_IDLE;
                    end
                    else
                        state_next = tksk_pkg::ST_SEL;
                end
            end
            tksk_pkg::ST_EMPTY:
            begin
                if (out_free)
                begin
                    ov_next    = 1'b1;
                    ovr_next   = 1'b0;
                    olast_next = 1'b1;
                    state_next = tksk_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = tksk_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ hw/rtl/top_k_score_keeper.sv @@
// ----------------------------------------------------------------------------
// top_k_score_keeper: keeps the best-scoring match records
// Front queue plus back-end store with a one-slot-per-cycle scan sequencer.
// ----------------------------------------------------------------------------
// Usage:
//   in channel (in_valid/in_ready) carries op, score, pack_no,
//   struct_offset, start_pos. op 0 inserts, 1 reads out, 2 clears.
//   out channel (out_valid/out_ready) returns valid_res, out_score,
//   out_pack, out_offset, out_start, last.
//   the user writes max_keep via cfg_we/cfg_wdata only while the block is idle; the block has no guard for it.
// Sequence:
//   an insert into a store with room goes straight to the write state; once
//   full, the minimum search scans every occupied slot before the write.
//   a read-out of n records takes n selection passes over the occupied slots,
//   each followed by an emit step; the store read port walks one slot per cycle.
// Reset: store is emptied (count zero), max_keep is 64.
// Stall: a held result stalls the back end in its emit and empty-result states;
//   the two-entry input queue keeps accepting until it fills.
// ----------------------------------------------------------------------------
`default_nettype none

module top_k_score_keeper #(
    parameter int unsigned CAPACITY = tksk_pkg::CAPACITY_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [6:0]  cfg_wdata,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  op,
    input  wire logic [15:0] score,
    input  wire logic [14:0] pack_no,
    input  wire logic [31:0] struct_offset,
    input  wire logic [15:0] start_pos,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic             valid_res,
    output logic [15:0]      out_score,
    output logic [14:0]      out_pack,
    output logic [31:0]      out_offset,
    output logic [15:0]      out_start,
    output logic             last
);

    logic [6:0]      max_keep_reg;
    tksk_pkg::cmd_t  in_cmd, cmd;
    logic            cmd_valid, cmd_ready;

    // limit register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            max_keep_reg <= tksk_pkg::KEEP_RESET;
        else if (cfg_we)
            max_keep_reg <= cfg_wdata;
    end

    assign in_cmd.op            = tksk_pkg::op_t'(op);
    assign in_cmd.score         = score;
    assign in_cmd.pack_no       = pack_no;
    assign in_cmd.struct_offset = struct_offset;
    assign in_cmd.start_pos     = start_pos;

    tksk_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_cmd    (in_cmd),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd)
    );

    tksk_back #(.CAPACITY(CAPACITY)) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .max_keep   (max_keep_reg),
        .cmd_valid  (cmd_valid),
        .cmd_ready  (cmd_ready),
        .cmd        (cmd),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .valid_res  (valid_res),
        .out_score  (out_score),
        .out_pack   (out_pack),
        .out_offset (out_offset),
        .out_start  (out_start),
        .last       (last)
    );

endmodule

`default_nettype wire

@@ hw/rtl/tksk_checker.sv @@
// ----------------------------------------------------------------------------
// tksk_checker: port-level checks of the top-k score keeper
// Watches the output channel and is bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module tksk_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic        valid_res,
    input wire logic [15:0] out_score,
    input wire logic        last
);

    // a stalled beat holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_score))
        else $error("output beat changed while stalled");

    // an empty result is a one-beat run
    a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !valid_res |-> last)
        else $error("empty result without last");

    // scores within a run never rise
    a_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !last ##1 out_valid && out_ready
            |-> out_score <= $past(out_score))
        else $error("read-out out of order");

endmodule

bind top_k_score_keeper tksk_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .valid_res (valid_res),
    .out_score (out_score),
    .last      (last)
);

`default_nettype wire
